>>> rtl/core/acca_pkg.sv
`default_nettype none
package acca_pkg;

  localparam int CLUMP_INFO_BYTES   = 25;
  localparam int CLUMP_HEADER_BYTES = 38;
  localparam int TRAILER_WORD_BYTES = 4;
  localparam int FLUSH_MASK         = 511;
  localparam int MAX_SEGMENTS       = 34;

  localparam int FLUSH_BITS = $clog2(FLUSH_MASK + 1);

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_SEALED = 2'd2;
  localparam logic [1:0] ST_WRAP   = 2'd3;

  // register indexes
  localparam logic [1:0] REG_DATA_BASE   = 2'd0;
  localparam logic [1:0] REG_DATA_SIZE   = 2'd1;
  localparam logic [1:0] REG_BLOCK_SHIFT = 2'd2;

  typedef struct packed {
    logic [47:0] data_base;
    logic [39:0] data_size;
    logic [4:0]  block_shift;
  } cfg_t;

  // one classified transaction handed from front to back
  typedef struct packed {
    logic        refuse;
    logic [1:0]  status;
    logic        flush;
    logic [4:0]  shift;
    logic [39:0] coff;
    logic [31:0] idx;
    logic [47:0] addr;
    logic [15:0] off;
    logic [16:0] len;
    logic [47:0] daddr;
    logic [15:0] eoff;
  } job_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [39:0] clump_offset;
    logic [31:0] clump_index;
    logic [47:0] segment_address;
    logic [15:0] segment_offset;
    logic [16:0] segment_length;
    logic [47:0] dir_block_address;
    logic [15:0] dir_entry_offset;
    logic        flush_directory;
    logic        last;
  } result_t;

  function automatic logic [4:0] eff_shift(input logic [4:0] s);
    logic [4:0] r;
    if (s < 5'd11)      r = 5'd11;
    else if (s > 5'd16) r = 5'd16;
    else                r = s;
    return r;
  endfunction

  // directory entries per block, per clamped shift
  function automatic logic [11:0] entries_per_block(input logic [4:0] s);
    logic [11:0] r;
    case (s)
      5'd11:   r = 12'((32'd1 << 11) / CLUMP_INFO_BYTES);
      5'd12:   r = 12'((32'd1 << 12) / CLUMP_INFO_BYTES);
      5'd13:   r = 12'((32'd1 << 13) / CLUMP_INFO_BYTES);
      5'd14:   r = 12'((32'd1 << 14) / CLUMP_INFO_BYTES);
      5'd15:   r = 12'((32'd1 << 15) / CLUMP_INFO_BYTES);
      default: r = 12'((32'd1 << 16) / CLUMP_INFO_BYTES);
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/acca_if.sv
`default_nettype none
interface acca_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] stored_size;
  logic [15:0] raw_size;
  modport source (output valid, stored_size, raw_size, input ready);
  modport sink   (input valid, stored_size, raw_size, output ready);
endinterface

interface acca_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [39:0] clump_offset;
  logic [31:0] clump_index;
  logic [47:0] segment_address;
  logic [15:0] segment_offset;
  logic [16:0] segment_length;
  logic [47:0] dir_block_address;
  logic [15:0] dir_entry_offset;
  logic        flush_directory;
  logic        last;
  modport source (output valid, status, clump_offset, clump_index, segment_address,
                  segment_offset, segment_length, dir_block_address, dir_entry_offset,
                  flush_directory, last, input ready);
  modport sink   (input valid, status, clump_offset, clump_index, segment_address,
                  segment_offset, segment_length, dir_block_address, dir_entry_offset,
                  flush_directory, last, output ready);
endinterface
`default_nettype wire

>>> rtl/core/acca_front.sv
`default_nettype none
module acca_front
  import acca_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cfg_t        cfg,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] in_stored,
  input  wire logic [15:0] in_raw,
  output logic             push,
  output job_t             push_job,
  input  wire logic        push_ready
);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_DECIDE} state_t;

  state_t      state_r;
  logic [39:0] used_r;
  logic [31:0] count_r;
  logic [31:0] comp_r;
  logic [47:0] rawt_r;
  logic        sealed_r;
  logic [15:0] stored_r;
  logic [15:0] raw_r;
  logic [31:0] q_r;
  logic [11:0] rem_r;
  logic [4:0]  cnt_r;

  logic [4:0]  sh;
  logic [11:0] epb;
  logic [12:0] trial;
  logic        take;
  logic [16:0] bs;
  logic [47:0] start;
  logic [15:0] off;
  logic [47:0] addr;
  logic [16:0] n;
  logic [17:0] span;
  logic [7:0]  nsegs;
  logic        wrap;
  logic [31:0] q1;
  logic [51:0] need;
  logic        full;
  logic [47:0] daddr;
  logic [15:0] eoff;

  always_comb begin
    sh    = eff_shift(cfg.block_shift);
    epb   = entries_per_block(sh);
    trial = {rem_r, q_r[31]};
    take  = trial >= {1'b0, epb};
    bs    = 17'd1 << sh;
    start = cfg.data_base + 48'(used_r);
    off   = start[15:0] & (bs[15:0] - 16'd1);
    addr  = {start[47:16], start[15:0] & ~(bs[15:0] - 16'd1)};
    n     = 17'(stored_r) + 17'(CLUMP_HEADER_BYTES);
    span  = 18'(off) + 18'(n) + 18'(bs) - 18'd1;
    nsegs = 8'(span >> sh);
    wrap  = &count_r;
    if (wrap)                          q1 = 32'd0;
    else if (rem_r + 12'd1 == epb)     q1 = q_r + 32'd1;
    else                               q1 = q_r;
    need  = 52'(used_r) + 52'(n) + 52'(TRAILER_WORD_BYTES)
          + ((52'(q1) + 52'd1) << sh);
    full  = (need > 52'(cfg.data_size)) || (nsegs > 8'(MAX_SEGMENTS));
    daddr = cfg.data_base + 48'(cfg.data_size) - 48'((49'(q_r) + 49'd1) << sh);
    eoff  = 16'(rem_r) * 16'(CLUMP_INFO_BYTES);
  end

  always_comb begin
    in_ready = (state_r == S_IDLE);
    push     = (state_r == S_DECIDE);
    push_job = '0;
    push_job.shift = sh;
    if (sealed_r) begin
      push_job.refuse = 1'b1;
      push_job.status = ST_SEALED;
    end else if (full) begin
      push_job.refuse = 1'b1;
      push_job.status = ST_FULL;
      push_job.flush  = 1'b1;
    end else begin
      push_job.status = wrap ? ST_WRAP : ST_OK;
      push_job.flush  = (count_r[FLUSH_BITS-1:0] & FLUSH_BITS'(FLUSH_MASK))
                        == FLUSH_BITS'(FLUSH_MASK);
      push_job.coff   = used_r;
      push_job.idx    = count_r;
      push_job.addr   = addr;
      push_job.off    = off;
      push_job.len    = n;
      push_job.daddr  = daddr;
      push_job.eoff   = eoff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      used_r   <= '0;
      count_r  <= '0;
      comp_r   <= '0;
      rawt_r   <= '0;
      sealed_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            stored_r <= in_stored;
            raw_r    <= in_raw;
            q_r      <= count_r;
            rem_r    <= '0;
            cnt_r    <= 5'd31;
            state_r  <= sealed_r ? S_DECIDE : S_DIV;
          end
        end
        S_DIV: begin
          q_r   <= {q_r[30:0], take};
          rem_r <= take ? 12'(trial - {1'b0, epb}) : trial[11:0];
          cnt_r <= cnt_r - 5'd1;
          if (cnt_r == 5'd0) state_r <= S_DECIDE;
        end
        S_DECIDE: begin
          if (push_ready) begin
            state_r <= S_IDLE;
            if (!sealed_r) begin
              if (full) begin
                sealed_r <= 1'b1;
              end else begin
                used_r  <= used_r + 40'(n);
                rawt_r  <= rawt_r + 48'(raw_r);
                if (stored_r < raw_r) comp_r <= comp_r + 32'd1;
                count_r <= count_r + 32'd1;
              end
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/acca_queue.sv
`default_nettype none
module acca_queue
  import acca_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr,
  input  wire job_t wr_job,
  output logic      wr_ready,
  input  wire logic rd,
  output job_t      rd_job,
  output logic      rd_valid
);

  job_t       mem_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  logic       do_wr;
  logic       do_rd;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_job   = mem_r[rp_r];
  assign do_wr    = wr && wr_ready;
  assign do_rd    = rd && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wp_r] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (do_wr) wp_r <= ~wp_r;
      if (do_rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(do_wr) - 2'(do_rd);
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/acca_back.sv
`default_nettype none
module acca_back
  import acca_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire job_t job,
  input  wire logic job_valid,
  output logic      job_pop,
  output result_t   res,
  output logic      res_valid,
  input  wire logic res_ready
);

  job_t        cur_r;
  logic        active_r;
  logic [16:0] rem_r;
  logic [15:0] off_r;
  logic [47:0] addr_r;
  result_t     res_r;
  logic        ovalid_r;

  logic [16:0] bs;
  logic [16:0] room;
  logic [16:0] m;
  logic        is_last;
  logic        load;
  logic        emit;
  result_t     seg;

  always_comb begin
    bs      = 17'd1 << cur_r.shift;
    room    = bs - 17'(off_r);
    m       = (room < rem_r) ? room : rem_r;
    is_last = (m == rem_r);
    load    = !ovalid_r || res_ready;
    job_pop = !active_r && job_valid;
    emit    = active_r && load;
    seg     = '0;
    seg.status          = cur_r.status;
    seg.flush_directory = cur_r.flush;
    if (cur_r.refuse) begin
      seg.last = 1'b1;
    end else begin
      seg.clump_offset      = cur_r.coff;
      seg.clump_index       = cur_r.idx;
      seg.segment_address   = addr_r;
      seg.segment_offset    = off_r;
      seg.segment_length    = m;
      seg.dir_block_address = cur_r.daddr;
      seg.dir_entry_offset  = cur_r.eoff;
      seg.last              = is_last;
    end
  end

  assign res       = res_r;
  assign res_valid = ovalid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      ovalid_r <= emit || (ovalid_r && !res_ready);
      if (job_pop) begin
        cur_r    <= job;
        rem_r    <= job.len;
        off_r    <= job.off;
        addr_r   <= job.addr;
        active_r <= 1'b1;
      end else if (emit) begin
        res_r    <= seg;
        rem_r    <= rem_r - m;
        off_r    <= '0;
        addr_r   <= addr_r + 48'(bs);
        if (cur_r.refuse || is_last) active_r <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/arena_clump_append_allocator_unit.sv
// Each request runs a 32-step directory divide in the front, skipped on an
//   already sealed arena; the back then emits one segment per cycle while the
//   output is not stalled. The front accepts no new request until the current
//   one is in the job queue; the back pops no new job before its last segment.
// Reset (synchronous, rst_n low): counters, used bytes and seal cleared,
//   block_shift to 13, base and size to 0, queue and output empty.
`default_nettype none
module arena_clump_append_allocator_unit
  import acca_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_idx,
  input  wire logic [47:0] cfg_wdata,
  acca_in_if.sink          in_chan,
  acca_out_if.source       out_chan
);

  // configuration registers
  cfg_t    cfg_r;

  // front -> queue
  logic    push;
  job_t    push_job;
  logic    push_ready;

  // queue -> back
  logic    pop;
  job_t    pop_job;
  logic    pop_valid;

  result_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.data_base   <= '0;
      cfg_r.data_size   <= '0;
      cfg_r.block_shift <= 5'd13;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_DATA_BASE:   cfg_r.data_base   <= cfg_wdata;
        REG_DATA_SIZE:   cfg_r.data_size   <= cfg_wdata[39:0];
        REG_BLOCK_SHIFT: cfg_r.block_shift <= cfg_wdata[4:0];
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  // front: accepts a transaction, divides the clump index by entries per
  // directory block, runs the fit test and advances the arena state
  acca_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_chan.valid),
    .in_ready   (in_chan.ready),
    .in_stored  (in_chan.stored_size),
    .in_raw     (in_chan.raw_size),
    .push       (push),
    .push_job   (push_job),
    .push_ready (push_ready)
  );

  // two-entry job queue decouples classification from segment emission
  acca_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (push),
    .wr_job   (push_job),
    .wr_ready (push_ready),
    .rd       (pop),
    .rd_job   (pop_job),
    .rd_valid (pop_valid)
  );

  // back: splits each job into block-aligned segments behind an output register
  acca_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (pop_job),
    .job_valid (pop_valid),
    .job_pop   (pop),
    .res       (res),
    .res_valid (out_chan.valid),
    .res_ready (out_chan.ready)
  );

  assign out_chan.status            = res.status;
  assign out_chan.clump_offset      = res.clump_offset;
  assign out_chan.clump_index       = res.clump_index;
  assign out_chan.segment_address   = res.segment_address;
  assign out_chan.segment_offset    = res.segment_offset;
  assign out_chan.segment_length    = res.segment_length;
  assign out_chan.dir_block_address = res.dir_block_address;
  assign out_chan.dir_entry_offset  = res.dir_entry_offset;
  assign out_chan.flush_directory   = res.flush_directory;
  assign out_chan.last              = res.last;

endmodule
`default_nettype wire
